>>> design/blop_pkg.sv
package blop_pkg;

    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

    typedef struct packed {
        logic        shift;
        logic        step;
        logic [1:0]  phase;
    } blop_ctrl_t;

    typedef struct packed {
        logic [31:0] p;
        logic [31:0] q;
        logic [31:0] d;
        logic [31:0] disc;
        logic [47:0] k;
        logic        put;
    } blop_coef_t;

    localparam logic [1:0] PH_MUL   = 2'd0;
    localparam logic [1:0] PH_PRICE = 2'd1;
    localparam logic [1:0] PH_DISC  = 2'd2;
    localparam logic [1:0] PH_VALUE = 2'd3;

    // (hi*2^24 + lo + 2^29) >> 30
    function automatic logic [51:0] rnd30(logic [55:0] hi, logic [55:0] lo);
        logic [81:0] t;
        t = {2'b0, hi, 24'b0} + {26'b0, lo} + (82'd1 << 29);
        return t[81:30];
    endfunction

    // (hi*2^24 + lo + 2^30) >> 31
    function automatic logic [50:0] rnd31(logic [56:0] hi, logic [56:0] lo);
        logic [81:0] t;
        t = {1'b0, hi, 24'b0} + {25'b0, lo} + (82'd1 << 30);
        return t[81:31];
    endfunction

    function automatic logic [47:0] exercise(logic [47:0] price, logic [47:0] k, logic put);
        logic [47:0] r;
        r = '0;
        if (put)
        begin
            if (k > price)
                r = k - price;
        end
        else
        begin
            if (price > k)
                r = price - k;
        end
        return r;
    endfunction

endpackage

>>> design/blop_if.sv
interface blop_in_if;
    logic        valid;
    logic        ready;
    logic [47:0] spot_price;
    logic [47:0] strike_price;
    logic        is_put;
    logic [31:0] up_factor;
    logic [31:0] down_factor;
    logic [31:0] prob_up;
    logic [31:0] step_discount;

    modport source (output valid, spot_price, strike_price, is_put, up_factor,
                    down_factor, prob_up, step_discount, input ready);
    modport sink (input valid, spot_price, strike_price, is_put, up_factor,
                  down_factor, prob_up, step_discount, output ready);
endinterface

interface blop_out_if;
    logic        valid;
    logic        ready;
    logic [47:0] option_value;
    logic        saturated;

    modport source (output valid, option_value, saturated, input ready);
    modport sink (input valid, option_value, saturated, output ready);
endinterface

>>> design/blop_cell.sv
module blop_cell
    import blop_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 9
)
(
    input  logic          clk,
    input  blop_ctrl_t    ctrl,
    input  blop_coef_t    coef,
    input  logic [CW-1:0] thr,
    input  logic [47:0]   prev_price,
    input  logic [47:0]   prev_value,
    output logic [47:0]   price,
    output logic [47:0]   value,
    output logic          sat
);

    logic [47:0] price_reg, value_reg, e_reg;
    logic        sat_reg;
    logic [55:0] ph_reg, pl_reg, ch_reg, cl_reg;
    logic [56:0] eh_reg, el_reg;
    logic        active;
    logic [51:0] pr;
    logic [50:0] er, cr;
    logic [47:0] x;

    assign active = (CW'(IDX) >= thr);
    assign pr = rnd30(ph_reg, pl_reg);
    assign er = rnd31(eh_reg, el_reg);
    assign cr = rnd31({1'b0, ch_reg}, {1'b0, cl_reg});
    assign x  = exercise(price_reg, coef.k, coef.put);

    always_ff @(posedge clk)
    begin
        ph_reg <= 56'(price_reg[47:24]) * 56'(coef.d);
        pl_reg <= 56'(price_reg[23:0]) * 56'(coef.d);
        eh_reg <= 57'(value_reg[47:24]) * 57'(coef.p) + 57'(prev_value[47:24]) * 57'(coef.q);
        el_reg <= 57'(value_reg[23:0]) * 57'(coef.p) + 57'(prev_value[23:0]) * 57'(coef.q);
        ch_reg <= 56'(e_reg[47:24]) * 56'(coef.disc);
        cl_reg <= 56'(e_reg[23:0]) * 56'(coef.disc);
        if (ctrl.shift)
        begin
            price_reg <= prev_price;
            value_reg <= prev_value;
            sat_reg   <= 1'b0;
        end
        else if (ctrl.step && active)
        begin
            case (ctrl.phase)
                PH_PRICE:
                begin
                    e_reg <= er[47:0];
                    if (|pr[51:48])
                    begin
                        price_reg <= '1;
                        sat_reg   <= 1'b1;
                    end
                    else
                        price_reg <= pr[47:0];
                end
                PH_VALUE:
                    value_reg <= (cr[47:0] > x) ? cr[47:0] : x;
                default:
                    ;
            endcase
        end
    end

    assign price = price_reg;
    assign value = value_reg;
    assign sat   = sat_reg;

endmodule

>>> design/binomial_lattice_option_pricer.sv
// American option pricer on a CRR lattice.
// in_ch carries one option per transfer (spot, strike, call/put, u, d, p,
// per-step discount); out_ch returns the root value and a saturation flag.
// step_count_we/step_count_wdata set the step count n (0 reads as 1, values
// above MAX_STEPS read as MAX_STEPS); write it only while idle.
// One option at a time: in_ch.ready is high only while idle. After an input
// transfer the block computes the u power on the shared multiplier, builds
// and shifts in the terminal nodes (two d multiplies each), does the padding
// shifts, runs each backward step across the cell row (multiply,
// price/expectation round, discount multiply, value update), then moves the
// result through the finish state into the output register.
// The result sits in an output register; a new option is accepted while it
// waits. If the receiver still stalls when the next result is ready, the
// block holds that result inside until out_ch.ready.
// Reset returns to idle with no result pending and step count 256.
module binomial_lattice_option_pricer
    import blop_pkg::*;
#(
    parameter int MAX_STEPS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_count_we,
    input  logic [8:0]  step_count_wdata,
    blop_in_if.sink     in_ch,
    blop_out_if.source  out_ch
);

    localparam int CW = $clog2(MAX_STEPS + 1);
    localparam int NC = MAX_STEPS + 1;
    localparam int WW = (CW > 9) ? CW : 9;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UP   = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_DD   = 3'd3;
    localparam logic [2:0] S_PAD  = 3'd4;
    localparam logic [2:0] S_STEP = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]    state_reg;
    logic [8:0]    step_count_reg;
    logic [CW-1:0] n_reg, cnt_reg, s_reg;
    logic [1:0]    sub_reg;
    logic [47:0]   cur_reg;
    logic [55:0]   mh_reg, ml_reg;
    logic          sat_reg;
    logic          out_valid_reg, out_sat_reg;
    logic [47:0]   out_val_reg;
    blop_coef_t    coef_reg;
    logic [31:0]   u_reg;

    logic [CW-1:0] n_eff, pad;
    logic [WW-1:0] cfg_ext;
    logic [31:0]   mf, p_in, disc_in;
    logic [51:0]   mr;
    logic          msat;
    logic [47:0]   mres;
    blop_ctrl_t    ctrl;
    logic [47:0]   load_price, load_value;
    logic [CW-1:0] thr;
    logic [47:0]   prices [NC];
    logic [47:0]   values [NC];
    logic [NC-1:0] sats;
    logic          in_xfer, fin_go;

    assign cfg_ext = WW'(step_count_reg);
    always_comb
    begin
        if (step_count_reg == 9'd0)
            n_eff = CW'(1);
        else if (cfg_ext > WW'(MAX_STEPS))
            n_eff = CW'(MAX_STEPS);
        else
            n_eff = CW'(cfg_ext);
    end

    assign pad     = CW'(MAX_STEPS) - n_reg;
    assign p_in    = (in_ch.prob_up > ONE_Q31) ? ONE_Q31 : in_ch.prob_up;
    assign disc_in = (in_ch.step_discount > ONE_Q31) ? ONE_Q31 : in_ch.step_discount;
    assign in_xfer = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign fin_go  = (state_reg == S_FIN) && (!out_valid_reg || out_ch.ready);

    assign mf   = (state_reg == S_UP) ? u_reg : coef_reg.d;
    assign mr   = rnd30(mh_reg, ml_reg);
    assign msat = |mr[51:48];
    assign mres = msat ? '1 : mr[47:0];

    assign ctrl.shift = (state_reg == S_LOAD) || (state_reg == S_PAD);
    assign ctrl.step  = (state_reg == S_STEP);
    assign ctrl.phase = sub_reg;
    assign thr        = CW'(MAX_STEPS) - s_reg;
    assign load_price = (state_reg == S_LOAD) ? cur_reg : '0;
    assign load_value = (state_reg == S_LOAD) ? exercise(cur_reg, coef_reg.k, coef_reg.put) : '0;

    for (genvar j = 0; j < NC; j++)
    begin : g_cell
        blop_cell #(.IDX(j), .CW(CW)) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .coef       (coef_reg),
            .thr        (thr),
            .prev_price ((j == 0) ? load_price : prices[(j == 0) ? 0 : j - 1]),
            .prev_value ((j == 0) ? load_value : values[(j == 0) ? 0 : j - 1]),
            .price      (prices[j]),
            .value      (values[j]),
            .sat        (sats[j])
        );
    end

    always_ff @(posedge clk)
    begin
        mh_reg <= 56'(cur_reg[47:24]) * 56'(mf);
        ml_reg <= 56'(cur_reg[23:0]) * 56'(mf);
        if (in_xfer)
        begin
            coef_reg.p    <= p_in;
            coef_reg.q    <= ONE_Q31 - p_in;
            coef_reg.d    <= in_ch.down_factor;
            coef_reg.disc <= disc_in;
            coef_reg.k    <= in_ch.strike_price;
            coef_reg.put  <= in_ch.is_put;
            u_reg         <= in_ch.up_factor;
        end
        if (fin_go)
        begin
            out_val_reg <= values[NC-1];
            out_sat_reg <= sat_reg | (|sats);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_count_reg <= 9'd256;
            n_reg          <= '0;
            cnt_reg        <= '0;
            s_reg          <= '0;
            sub_reg        <= '0;
            cur_reg        <= '0;
            sat_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (step_count_we)
                step_count_reg <= step_count_wdata;
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_xfer)
                    begin
                        cur_reg   <= in_ch.spot_price;
                        n_reg     <= n_eff;
                        cnt_reg   <= n_eff;
                        sat_reg   <= 1'b0;
                        sub_reg   <= '0;
                        state_reg <= S_UP;
                    end
                S_UP:
                begin
                    sub_reg <= {1'b0, ~sub_reg[0]};
                    if (sub_reg[0])
                    begin
                        cur_reg <= mres;
                        sat_reg <= sat_reg | msat;
                        cnt_reg <= cnt_reg - CW'(1);
                        if (cnt_reg == CW'(1))
                        begin
                            cnt_reg   <= n_reg;
                            state_reg <= S_LOAD;
                        end
                    end
                end
                S_LOAD:
                begin
                    sub_reg <= '0;
                    if (cnt_reg == '0)
                    begin
                        cnt_reg <= pad;
                        s_reg   <= n_reg - CW'(1);
                        state_reg <= (pad == '0) ? S_STEP : S_PAD;
                    end
                    else
                        state_reg <= S_DD;
                end
                S_DD:
                begin
                    sub_reg <= sub_reg + 2'd1;
                    if (sub_reg[0])
                    begin
                        cur_reg <= mres;
                        sat_reg <= sat_reg | msat;
                    end
                    if (sub_reg == 2'd3)
                    begin
                        cnt_reg   <= cnt_reg - CW'(1);
                        state_reg <= S_LOAD;
                    end
                end
                S_PAD:
                begin
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                        state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    sub_reg <= sub_reg + 2'd1;
                    if (sub_reg == PH_VALUE)
                    begin
                        if (s_reg == '0)
                            state_reg <= S_FIN;
                        else
                            s_reg <= s_reg - CW'(1);
                    end
                end
                S_FIN:
                    if (fin_go)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.option_value = out_val_reg;
    assign out_ch.saturated    = out_sat_reg;

    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == S_UP))
        else $error("pricer not busy after input transfer");

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP) |-> (s_reg < n_reg))
        else $error("step index out of range");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside finish");

    a_pad_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PAD) |-> (cnt_reg != '0))
        else $error("padding with empty count");

endmodule

>>> tb/testbench.sv
module testbench;
    import blop_pkg::*;

    localparam int          N_MAX   = 256;
    localparam int          LIMIT   = 3000000;
    localparam logic [47:0] MAX48   = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    typedef struct packed {
        logic [47:0] spot;
        logic [47:0] strike;
        logic        put;
        logic [31:0] u;
        logic [31:0] d;
        logic [31:0] p;
        logic [31:0] disc;
    } option_t;

    typedef struct packed {
        logic [47:0] value;
        logic        sat;
    } price_t;

    typedef struct packed {
        option_t     opt;
        logic        known;
        price_t      res;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic step_count_we;
    logic [8:0] step_count_wdata;

    blop_in_if  in_ch();
    blop_out_if out_ch();

    binomial_lattice_option_pricer #(.MAX_STEPS(N_MAX)) i_dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .step_count_we    (step_count_we),
        .step_count_wdata (step_count_wdata),
        .in_ch            (in_ch),
        .out_ch           (out_ch)
    );

    price_t      pending_prices[$];
    logic [8:0]  cur_steps;
    int          errors;
    int          cycles;
    bit          quiet;
    bit          hold_req;
    logic        pred_sat;
    dir_row_t    dir_tab[14];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic logic [47:0] scale_price(logic [47:0] pr, logic [31:0] f);
        logic [80:0] t;
        t = ({33'b0, pr} * {49'b0, f} + (81'd1 << 29)) >> 30;
        if (t > {33'b0, MAX48})
        begin
            pred_sat = 1'b1;
            return MAX48;
        end
        return t[47:0];
    endfunction

    function automatic logic [47:0] payoff(logic [47:0] pr, logic [47:0] k, logic put);
        if (put)
            return (k > pr) ? k - pr : 48'd0;
        return (pr > k) ? pr - k : 48'd0;
    endfunction

    function automatic price_t price_option(option_t o, logic [8:0] steps);
        logic [47:0] px[N_MAX+1];
        logic [47:0] vx[N_MAX+1];
        logic [95:0] e;
        logic [95:0] c;
        logic [47:0] x;
        logic [31:0] p;
        logic [31:0] q;
        logic [31:0] disc;
        price_t      r;
        int          n;
        n = (steps == 0) ? 1 : ((steps > N_MAX) ? N_MAX : int'(steps));
        p = (o.p > ONE_Q31) ? ONE_Q31 : o.p;
        disc = (o.disc > ONE_Q31) ? ONE_Q31 : o.disc;
        q = ONE_Q31 - p;
        pred_sat = 1'b0;
        px[0] = o.spot;
        for (int i = 0; i < n; i++)
            px[0] = scale_price(px[0], o.u);
        for (int i = 1; i <= n; i++)
            px[i] = scale_price(scale_price(px[i-1], o.d), o.d);
        for (int i = 0; i <= n; i++)
            vx[i] = payoff(px[i], o.strike, o.put);
        for (int s = n - 1; s >= 0; s--)
        begin
            for (int i = 0; i <= s; i++)
            begin
                px[i] = scale_price(px[i], o.d);
                e = ({48'b0, vx[i]} * {64'b0, p} + {48'b0, vx[i+1]} * {64'b0, q}
                     + (96'd1 << 30)) >> 31;
                c = (e * {64'b0, disc} + (96'd1 << 30)) >> 31;
                x = payoff(px[i], o.strike, o.put);
                vx[i] = (c[47:0] > x) ? c[47:0] : x;
            end
        end
        r.value = vx[0];
        r.sat = pred_sat;
        return r;
    endfunction

    function automatic option_t make_option(bit sane);
        option_t o;
        if (sane)
        begin
            o.spot = {8'b0, 16'($urandom_range(1, 2000)), 24'($urandom)};
            o.strike = {8'b0, 16'($urandom_range(1, 2000)), 24'($urandom)};
            o.u = ONE_Q30 + $urandom_range(0, 32'h0400_0000);
            o.d = ONE_Q30 - $urandom_range(0, 32'h0400_0000);
            o.p = 32'h4000_0000 + $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
            o.disc = ONE_Q31 - $urandom_range(0, 32'h0040_0000);
        end
        else
        begin
            o.spot = {16'($urandom), 32'($urandom)};
            o.strike = ($urandom_range(0, 3) == 0) ? o.spot : {16'($urandom), 32'($urandom)};
            o.u = $urandom;
            o.d = $urandom;
            o.p = ($urandom_range(0, 1) == 0) ? $urandom : ONE_Q31 - $urandom_range(0, 1);
            o.disc = ($urandom_range(0, 1) == 0) ? $urandom : ONE_Q31 + $urandom_range(0, 1);
        end
        o.put = 1'($urandom);
        return o;
    endfunction

    task automatic send_option(option_t o, bit known, price_t res);
        int gap;
        in_ch.spot_price    <= o.spot;
        in_ch.strike_price  <= o.strike;
        in_ch.is_put        <= o.put;
        in_ch.up_factor     <= o.u;
        in_ch.down_factor   <= o.d;
        in_ch.prob_up       <= o.p;
        in_ch.step_discount <= o.disc;
        in_ch.valid         <= 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        pending_prices.push_back(known ? res : price_option(o, cur_steps));
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain;
        while (pending_prices.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_steps(logic [8:0] v);
        in_ch.valid <= 1'b0;
        drain();
        repeat (4) @(posedge clk);
        step_count_we    <= 1'b1;
        step_count_wdata <= v;
        @(posedge clk);
        step_count_we    <= 1'b0;
        cur_steps = v;
    endtask

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int idle_left;
        price_t want;
        idle_left = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_prices.size() == 0)
                begin
                    $error("unexpected result transfer: option_value %h", out_ch.option_value);
                    errors++;
                end
                else
                begin
                    want = pending_prices.pop_front();
                    if (out_ch.option_value !== want.value)
                    begin
                        $error("option_value: expected %h, actual %h", want.value,
                               out_ch.option_value);
                        errors++;
                    end
                    if (out_ch.saturated !== want.sat)
                    begin
                        $error("saturated: expected %b, actual %b", want.sat, out_ch.saturated);
                        errors++;
                    end
                end
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                idle_left = 3000;
            end
            if (idle_left > 0)
            begin
                out_ch.ready <= 1'b0;
                idle_left--;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_ch.ready <= 1'b0;
                idle_left = $urandom_range(1, 11) - 1;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        logic [8:0] steps;
        int         cnt;
        price_t     none;
        errors = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        none = '0;
        cur_steps = 9'd256;
        rst_n = 1'b0;
        step_count_we = 1'b0;
        step_count_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.spot_price = '0;
        in_ch.strike_price = '0;
        in_ch.is_put = 1'b0;
        in_ch.up_factor = '0;
        in_ch.down_factor = '0;
        in_ch.prob_up = '0;
        in_ch.step_discount = '0;

        //           spot       strike            put u         d             p
        //           disc                         known  value / sat
        dir_tab[0]  = '{'{48'd0, 48'd100 << 24, 1'b0, 32'h4100_0000, 32'h3F00_0000,
                          32'h4000_0000, 32'h7FF0_0000}, 1'b1, '{48'd0, 1'b0}};
        dir_tab[1]  = '{'{48'd0, 48'd100 << 24, 1'b1, 32'h4100_0000, 32'h3F00_0000,
                          32'h4000_0000, ONE_Q31}, 1'b1, '{48'd100 << 24, 1'b0}};
        dir_tab[2]  = '{'{48'd0, MAX48, 1'b1, 32'h4100_0000, 32'h3F00_0000,
                          32'h0, ONE_Q31}, 1'b1, '{MAX48, 1'b0}};
        // discount above one clamps
        dir_tab[3]  = '{'{48'd0, 48'd5 << 24, 1'b1, 32'h4100_0000, 32'h3F00_0000,
                          32'h4000_0000, 32'hFFFF_FFFF}, 1'b1, '{48'd5 << 24, 1'b0}};
        // probability above one clamps
        dir_tab[4]  = '{'{48'd0, 48'd7 << 24, 1'b1, 32'h4100_0000, 32'h3F00_0000,
                          32'hFFFF_FFFF, ONE_Q31}, 1'b1, '{48'd7 << 24, 1'b0}};
        dir_tab[5]  = '{'{MAX48, 48'd0, 1'b0, ONE_Q30, ONE_Q30,
                          32'h4000_0000, ONE_Q31}, 1'b1, '{MAX48, 1'b0}};
        dir_tab[6]  = '{'{MAX48, 48'd0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          ONE_Q31, ONE_Q31}, 1'b0, none};
        dir_tab[7]  = '{'{MAX48, MAX48, 1'b1, 32'h0, 32'h0,
                          32'h0, 32'h0}, 1'b0, none};
        dir_tab[8]  = '{'{48'd100 << 24, 48'd100 << 24, 1'b1, 32'h4080_0000, 32'h3F80_0000,
                          32'h4000_0000, 32'h7FFF_0000}, 1'b0, none};
        dir_tab[9]  = '{'{48'd100 << 24, 48'd90 << 24, 1'b0, 32'h4080_0000, 32'h3F80_0000,
                          32'h4000_0000, 32'h7FFF_0000}, 1'b0, none};
        dir_tab[10] = '{'{48'd1, MAX48, 1'b0, 32'hFFFF_FFFF, ONE_Q30,
                          32'h7FFF_FFFF, 32'h0}, 1'b0, none};
        dir_tab[11] = '{'{48'd50 << 24, 48'd80 << 24, 1'b1, 32'h4200_0000, 32'h3E00_0000,
                          32'h3000_0000, 32'h7F00_0000}, 1'b0, none};
        dir_tab[12] = '{'{MAX48, 48'd1, 1'b1, 32'h8000_0000, 32'h2000_0000,
                          32'h2000_0000, 32'h6000_0000}, 1'b0, none};
        dir_tab[13] = '{'{48'hABCD_1234_5678, 48'h5432_10FE_DCBA, 1'b0, 32'h4001_0000,
                          32'h3FFF_0000, 32'h4000_0001, 32'h7FFF_FFFF}, 1'b0, none};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 14; i++)
            send_option(dir_tab[i].opt, dir_tab[i].known, dir_tab[i].res);

        for (int ph = 0; ph < 14; ph++)
        begin
            if (ph == 0)
                steps = 9'd0;
            else if (ph == 3)
                steps = 9'd511;
            else if (ph == 7)
                steps = 9'd256;
            else if (ph == 11)
                steps = 9'd255;
            else
                steps = 9'($urandom_range(0, 12));
            set_steps(steps);
            if (ph == 13)
                quiet = 1'b1;
            cnt = (ph % 4 == 3) ? 6 : 80;
            for (int j = 0; j < cnt; j++)
            begin
                if (ph == 1 && j == 10)
                    hold_req = 1'b1;
                if (ph == 2 && j == 40)
                begin
                    in_ch.valid <= 1'b0;
                    drain();
                end
                send_option(make_option($urandom_range(0, 4) != 0), 1'b0, none);
            end
        end
        in_ch.valid <= 1'b0;
        drain();
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
